>>> design/lspe_pkg.sv
// Shared types and constants for the LSB steganography payload extractor.
`default_nettype none

package lspe_pkg;

  // Configuration register reset values
  localparam logic [7:0] HDR_LEN_RST   = 8'd54;
  localparam logic [7:0] MAGIC_1_RST   = 8'd35;
  localparam logic [7:0] MAGIC_2_RST   = 8'd42;
  localparam logic       MAGIC_EN_RST  = 1'b1;

  // Field lengths in hidden bits
  localparam logic [7:0] CHAR_BITS = 8'd8;
  localparam logic [7:0] WORD_BITS = 8'd32;

  // Register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_HDR_LEN  = 2'd0,
    REG_MAGIC_1  = 2'd1,
    REG_MAGIC_2  = 2'd2,
    REG_MAGIC_EN = 2'd3
  } reg_idx_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_EXT_CHAR  = 2'd0,
    KIND_PAY_BYTE  = 2'd1,
    KIND_MAGIC_ERR = 2'd2,
    KIND_EMPTY     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_HEADER    = 3'd0,
    PH_MAGIC     = 3'd1,
    PH_EXT_LEN   = 3'd2,
    PH_EXT_CHARS = 3'd3,
    PH_PAY_SIZE  = 3'd4,
    PH_PAY_BYTES = 3'd5,
    PH_DONE      = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] cover_byte;
    logic       image_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] header_length;
    logic [7:0] magic_first;
    logic [7:0] magic_second;
    logic       magic_check_enable;
  } cfg_t;

endpackage

`default_nettype wire

>>> design/lsb_stego_payload_extractor_unit.sv
// Top level of the LSB steganography payload extractor.
// Usage: stream cover image bytes on the in_ channel, one item per byte, with
// image_start high on the first byte of each image. The block skips
// header_length bytes, then gathers bit 0 of each byte into magic characters,
// the extension length and characters, the payload size and payload bytes.
// Extension characters and payload bytes come out on the out_ channel; a magic
// mismatch or an empty payload gives one marker item with last set.
// A result passes through the input register, then the parse logic into the output
// register. Throughput: one item per cycle while the output register is not held
// by a low out_ready; the parse stage updates the frame state and loads the output
// register in the same cycle.
// When out_ready is low, the output register holds its item, the parse stage
// halts and the input register fills; in_ready then drops until the output
// register drains. An item that yields no result still waits its turn there.
// Reset (synchronous, rst_n low) empties both registers, returns the parser
// to header skip and loads the default register values. Configure through the
// cfg_ APB port only while the block is idle.
`default_nettype none

module lsb_stego_payload_extractor_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire lspe_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lspe_pkg::out_item_t      out_data,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [3:0]          cfg_paddr,
  input  wire logic [31:0]         cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);

  lspe_pkg::cfg_t      cfg;
  lspe_pkg::in_item_t  in_data_r;
  lspe_pkg::out_item_t res;
  logic                in_vld_r;
  logic                slot_free;
  logic                fire;
  logic                res_vld;

  assign fire     = in_vld_r && slot_free;
  assign in_ready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
  end

  lspe_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  lspe_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .in_data (in_data_r),
    .cfg     (cfg),
    .res_vld (res_vld),
    .res     (res)
  );

  lspe_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire && res_vld),
    .load_data (res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> design/lspe_cfg_regs.sv
// APB configuration registers of the extractor.
`default_nettype none

module lspe_cfg_regs (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_psel,
  input  wire logic           cfg_penable,
  input  wire logic           cfg_pwrite,
  input  wire logic [3:0]     cfg_paddr,
  input  wire logic [31:0]    cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready,
  output lspe_pkg::cfg_t      cfg
);

  lspe_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic [1:0]     idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = cfg_paddr[3:2];
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_length      <= lspe_pkg::HDR_LEN_RST;
      cfg_r.magic_first        <= lspe_pkg::MAGIC_1_RST;
      cfg_r.magic_second       <= lspe_pkg::MAGIC_2_RST;
      cfg_r.magic_check_enable <= lspe_pkg::MAGIC_EN_RST;
    end else if (wr_en) begin
      case (idx)
        lspe_pkg::REG_HDR_LEN:  cfg_r.header_length      <= cfg_pwdata[7:0];
        lspe_pkg::REG_MAGIC_1:  cfg_r.magic_first        <= cfg_pwdata[7:0];
        lspe_pkg::REG_MAGIC_2:  cfg_r.magic_second       <= cfg_pwdata[7:0];
        lspe_pkg::REG_MAGIC_EN: cfg_r.magic_check_enable <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      lspe_pkg::REG_HDR_LEN:  cfg_prdata = {24'd0, cfg_r.header_length};
      lspe_pkg::REG_MAGIC_1:  cfg_prdata = {24'd0, cfg_r.magic_first};
      lspe_pkg::REG_MAGIC_2:  cfg_prdata = {24'd0, cfg_r.magic_second};
      lspe_pkg::REG_MAGIC_EN: cfg_prdata = {31'd0, cfg_r.magic_check_enable};
      default:                cfg_prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

>>> design/lspe_parser.sv
// Frame parser: header skip, bit collection and field sequencing.
`default_nettype none

module lspe_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  wire lspe_pkg::in_item_t in_data,
  input  wire lspe_pkg::cfg_t     cfg,
  output logic                    res_vld,
  output lspe_pkg::out_item_t     res
);

  lspe_pkg::phase_t phase_r, phase_nxt, ph_w;
  logic [7:0]       bp_r, bp_nxt, bp_w, bp_inc;
  logic [31:0]      col_r, col_nxt, col_w, col_ins;
  logic [31:0]      rem_r, rem_nxt, rem_w, rem_dec;
  logic             mi_r, mi_nxt, mi_w;
  logic             hdr_skip;
  logic             char_done, word_done, word_pos, magic_bad;

  // Entry values: apply restart and the end of the header skip
  always_comb begin
    ph_w     = phase_r;
    bp_w     = bp_r;
    col_w    = col_r;
    rem_w    = rem_r;
    mi_w     = mi_r;
    hdr_skip = 1'b0;
    if (in_data.image_start) begin
      ph_w  = lspe_pkg::PH_HEADER;
      bp_w  = '0;
      col_w = '0;
      rem_w = '0;
      mi_w  = 1'b0;
    end
    if (ph_w == lspe_pkg::PH_HEADER) begin
      if (bp_w < cfg.header_length) begin
        hdr_skip = 1'b1;
      end else begin
        mi_w  = 1'b0;
        ph_w  = cfg.magic_check_enable ? lspe_pkg::PH_MAGIC : lspe_pkg::PH_EXT_LEN;
        bp_w  = '0;
        col_w = '0;
      end
    end
  end

  assign col_ins   = col_w | ({31'd0, in_data.cover_byte[0]} << bp_w[4:0]);
  assign bp_inc    = bp_w + 8'd1;
  assign rem_dec   = rem_w - 32'd1;
  assign char_done = (bp_inc >= lspe_pkg::CHAR_BITS);
  assign word_done = (bp_inc >= lspe_pkg::WORD_BITS);
  assign word_pos  = (col_ins != 32'd0) && !col_ins[31];
  assign magic_bad = col_ins[7:0] != (mi_w ? cfg.magic_second : cfg.magic_first);

  // Next state
  always_comb begin
    phase_nxt = ph_w;
    bp_nxt    = bp_w;
    col_nxt   = col_w;
    rem_nxt   = rem_w;
    mi_nxt    = mi_w;
    if (hdr_skip) begin
      bp_nxt = bp_inc;
    end else begin
      case (ph_w)
        lspe_pkg::PH_MAGIC: begin
          bp_nxt  = bp_inc;
          col_nxt = col_ins;
          if (char_done) begin
            bp_nxt  = '0;
            col_nxt = '0;
            if (magic_bad) begin
              phase_nxt = lspe_pkg::PH_DONE;
            end else if (mi_w) begin
              mi_nxt    = 1'b0;
              phase_nxt = lspe_pkg::PH_EXT_LEN;
            end else begin
              mi_nxt    = 1'b1;
              phase_nxt = lspe_pkg::PH_MAGIC;
            end
          end
        end
        lspe_pkg::PH_EXT_LEN, lspe_pkg::PH_PAY_SIZE: begin
          bp_nxt  = bp_inc;
          col_nxt = col_ins;
          if (word_done) begin
            bp_nxt  = '0;
            col_nxt = '0;
            if (word_pos) begin
              rem_nxt   = col_ins;
              phase_nxt = (ph_w == lspe_pkg::PH_EXT_LEN) ? lspe_pkg::PH_EXT_CHARS
                                                         : lspe_pkg::PH_PAY_BYTES;
            end else begin
              rem_nxt   = '0;
              phase_nxt = (ph_w == lspe_pkg::PH_EXT_LEN) ? lspe_pkg::PH_PAY_SIZE
                                                         : lspe_pkg::PH_DONE;
            end
          end
        end
        lspe_pkg::PH_EXT_CHARS, lspe_pkg::PH_PAY_BYTES: begin
          bp_nxt  = bp_inc;
          col_nxt = col_ins;
          if (char_done) begin
            bp_nxt  = '0;
            col_nxt = '0;
            rem_nxt = rem_dec;
            if (rem_dec == 32'd0) begin
              phase_nxt = (ph_w == lspe_pkg::PH_EXT_CHARS) ? lspe_pkg::PH_PAY_SIZE
                                                           : lspe_pkg::PH_DONE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result
  always_comb begin
    res_vld      = 1'b0;
    res.out_byte = 8'd0;
    res.out_kind = lspe_pkg::KIND_EXT_CHAR;
    res.last     = 1'b0;
    if (!hdr_skip) begin
      case (ph_w)
        lspe_pkg::PH_MAGIC: begin
          if (char_done && magic_bad) begin
            res_vld      = 1'b1;
            res.out_kind = lspe_pkg::KIND_MAGIC_ERR;
            res.last     = 1'b1;
          end
        end
        lspe_pkg::PH_EXT_CHARS: begin
          if (char_done) begin
            res_vld      = 1'b1;
            res.out_byte = col_ins[7:0];
          end
        end
        lspe_pkg::PH_PAY_SIZE: begin
          if (word_done && !word_pos) begin
            res_vld      = 1'b1;
            res.out_kind = lspe_pkg::KIND_EMPTY;
            res.last     = 1'b1;
          end
        end
        lspe_pkg::PH_PAY_BYTES: begin
          if (char_done) begin
            res_vld      = 1'b1;
            res.out_byte = col_ins[7:0];
            res.out_kind = lspe_pkg::KIND_PAY_BYTE;
            res.last     = (rem_w == 32'd1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lspe_pkg::PH_HEADER;
      bp_r    <= '0;
      col_r   <= '0;
      rem_r   <= '0;
      mi_r    <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      bp_r    <= bp_nxt;
      col_r   <= col_nxt;
      rem_r   <= rem_nxt;
      mi_r    <= mi_nxt;
    end
  end

  a_err_stops: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_vld && res.out_kind == lspe_pkg::KIND_MAGIC_ERR
    |=> phase_r == lspe_pkg::PH_DONE)
    else $error("magic mismatch did not stop the parser");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && res.out_kind == lspe_pkg::KIND_EMPTY |-> res.last)
    else $error("empty marker without last");

  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == lspe_pkg::PH_EXT_CHARS || phase_r == lspe_pkg::PH_PAY_BYTES)
    |-> rem_r != 32'd0)
    else $error("character phase with zero remaining count");

  a_bp_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != lspe_pkg::PH_HEADER |-> bp_r < lspe_pkg::WORD_BITS)
    else $error("bit position out of range inside a field");

endmodule

`default_nettype wire

>>> design/lspe_out_reg.sv
// Result register between the parser and the output channel.
`default_nettype none

module lspe_out_reg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire lspe_pkg::out_item_t load_data,
  output logic                     slot_free,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lspe_pkg::out_item_t      out_data
);

  logic                vld_r;
  lspe_pkg::out_item_t data_r;

  // Free when empty or when the held item leaves this cycle
  assign slot_free = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (slot_free) begin
      vld_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && load) begin
      data_r <= load_data;
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/lspe_checker.sv
`timescale 1ns / 100ps
// Checker for the stego extractor: tracks register writes, predicts recovered items, compares.
module lspe_checker (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire lspe_pkg::in_item_t  in_data,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire lspe_pkg::out_item_t out_data,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [3:0]          cfg_paddr,
  input  wire logic [31:0]         cfg_pwdata,
  input  wire logic                cfg_pready,
  input  wire logic                end_check,
  output int                       mismatches,
  output int                       results_due
);

  // register copy
  logic [7:0] hdr_len;
  logic [7:0] magic_a;
  logic [7:0] magic_b;
  logic       magic_on;

  // parser copy
  lspe_pkg::phase_t ph;
  logic [7:0]       bpos;
  logic [31:0]      coll;
  logic [31:0]      remain;
  logic             midx;

  lspe_pkg::out_item_t recovered_q[$];
  bit                  end_seen;

  initial begin
    mismatches  = 0;
    results_due = 0;
    end_seen    = 0;
  end

  task automatic report(input string msg);
    mismatches++;
    $display("[%0t] ERROR: %s", $time, msg);
  endtask

  task automatic new_field(input lspe_pkg::phase_t next);
    ph   = next;
    bpos = '0;
    coll = '0;
  endtask

  function automatic bit positive_len(input logic [31:0] v);
    return (v != 32'd0) && !v[31];
  endfunction

  task automatic decode_cover_byte(input lspe_pkg::in_item_t it);
    lspe_pkg::out_item_t r;
    bit                  emit;
    emit = 0;
    r    = '0;
    if (it.image_start) begin
      new_field(lspe_pkg::PH_HEADER);
      remain = '0;
      midx   = 1'b0;
    end
    if (ph == lspe_pkg::PH_HEADER) begin
      if (bpos < hdr_len) begin
        bpos = bpos + 8'd1;
        return;
      end
      midx = 1'b0;
      if (magic_on) new_field(lspe_pkg::PH_MAGIC);
      else new_field(lspe_pkg::PH_EXT_LEN);
    end
    if (ph == lspe_pkg::PH_DONE) return;

    coll = coll | (32'(it.cover_byte[0]) << bpos[4:0]);
    bpos = bpos + 8'd1;

    case (ph)
      lspe_pkg::PH_MAGIC: begin
        if (bpos >= lspe_pkg::CHAR_BITS) begin
          if (coll[7:0] != (midx ? magic_b : magic_a)) begin
            new_field(lspe_pkg::PH_DONE);
            r.out_byte = 8'd0;
            r.out_kind = lspe_pkg::KIND_MAGIC_ERR;
            r.last     = 1'b1;
            emit       = 1;
          end else if (midx) begin
            midx = 1'b0;
            new_field(lspe_pkg::PH_EXT_LEN);
          end else begin
            midx = 1'b1;
            new_field(lspe_pkg::PH_MAGIC);
          end
        end
      end
      lspe_pkg::PH_EXT_LEN: begin
        if (bpos >= lspe_pkg::WORD_BITS) begin
          if (positive_len(coll)) begin
            remain = coll;
            new_field(lspe_pkg::PH_EXT_CHARS);
          end else begin
            remain = '0;
            new_field(lspe_pkg::PH_PAY_SIZE);
          end
        end
      end
      lspe_pkg::PH_EXT_CHARS: begin
        if (bpos >= lspe_pkg::CHAR_BITS) begin
          r.out_byte = coll[7:0];
          r.out_kind = lspe_pkg::KIND_EXT_CHAR;
          r.last     = 1'b0;
          emit       = 1;
          remain     = remain - 32'd1;
          if (remain == 32'd0) new_field(lspe_pkg::PH_PAY_SIZE);
          else new_field(lspe_pkg::PH_EXT_CHARS);
        end
      end
      lspe_pkg::PH_PAY_SIZE: begin
        if (bpos >= lspe_pkg::WORD_BITS) begin
          if (positive_len(coll)) begin
            remain = coll;
            new_field(lspe_pkg::PH_PAY_BYTES);
          end else begin
            remain = '0;
            new_field(lspe_pkg::PH_DONE);
            r.out_byte = 8'd0;
            r.out_kind = lspe_pkg::KIND_EMPTY;
            r.last     = 1'b1;
            emit       = 1;
          end
        end
      end
      lspe_pkg::PH_PAY_BYTES: begin
        if (bpos >= lspe_pkg::CHAR_BITS) begin
          r.out_byte = coll[7:0];
          r.out_kind = lspe_pkg::KIND_PAY_BYTE;
          r.last     = (remain == 32'd1);
          emit       = 1;
          remain     = remain - 32'd1;
          if (remain == 32'd0) new_field(lspe_pkg::PH_DONE);
          else new_field(lspe_pkg::PH_PAY_BYTES);
        end
      end
      default: ;
    endcase
    if (emit) recovered_q.push_back(r);
  endtask

  task automatic check_result(input lspe_pkg::out_item_t got);
    lspe_pkg::out_item_t want;
    if (recovered_q.size() == 0) begin
      report($sformatf("unexpected result byte %02h kind %0d last %0b",
                       got.out_byte, got.out_kind, got.last));
      return;
    end
    want = recovered_q.pop_front();
    if (got.out_byte !== want.out_byte)
      report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
    if (got.out_kind !== want.out_kind)
      report($sformatf("out_kind %0d, want %0d", got.out_kind, want.out_kind));
    if (got.last !== want.last)
      report($sformatf("last %0b, want %0b (byte %02h)", got.last, want.last, want.out_byte));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      hdr_len  = lspe_pkg::HDR_LEN_RST;
      magic_a  = lspe_pkg::MAGIC_1_RST;
      magic_b  = lspe_pkg::MAGIC_2_RST;
      magic_on = lspe_pkg::MAGIC_EN_RST;
      new_field(lspe_pkg::PH_HEADER);
      remain   = '0;
      midx     = 1'b0;
      recovered_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (lspe_pkg::reg_idx_t'(cfg_paddr[3:2]))
          lspe_pkg::REG_HDR_LEN:  hdr_len  = cfg_pwdata[7:0];
          lspe_pkg::REG_MAGIC_1:  magic_a  = cfg_pwdata[7:0];
          lspe_pkg::REG_MAGIC_2:  magic_b  = cfg_pwdata[7:0];
          lspe_pkg::REG_MAGIC_EN: magic_on = cfg_pwdata[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) decode_cover_byte(in_data);
      if (end_check && !end_seen) begin
        end_seen = 1;
        if (recovered_q.size() != 0)
          report($sformatf("%0d results never arrived", recovered_q.size()));
      end
    end
    results_due = recovered_q.size();
  end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top of the stego extractor testbench: clock, reset, frame stimulus and verdict.
module testbench;

  localparam int ITEM_TARGET     = 1550;
  localparam int IDLE_LIMIT      = 3000;
  localparam int PRESSURE_CYCLES = 400;

  typedef enum int {
    FR_NORMAL,
    FR_EXT_ZERO,
    FR_EXT_NEG,
    FR_PAY_ZERO,
    FR_PAY_NEG,
    FR_MAGIC1_BAD,
    FR_MAGIC2_BAD,
    FR_TRUNCATED,
    FR_NOISE
  } frame_kind_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  lspe_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  lspe_pkg::out_item_t out_data;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [3:0]          cfg_paddr;
  logic [31:0]         cfg_pwdata;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;
  logic                end_check;
  int                  mismatches;
  int                  results_due;

  // settings the frames are built against
  logic [7:0] hl_set;
  logic [7:0] m1_set;
  logic [7:0] m2_set;
  logic       en_set;

  lspe_pkg::in_item_t frame_q[$];
  int                 items_sent;
  bit                 burst_tx;

  lsb_stego_payload_extractor_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  lspe_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .end_check   (end_check),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit positive_len(input logic [31:0] v);
    return (v != 32'd0) && !v[31];
  endfunction

  function automatic logic [31:0] neg_length();
    logic [31:0] v;
    v = $urandom;
    v[31] = 1'b1;
    case ($urandom_range(0, 2))
      0: v = 32'h8000_0000;
      1: v = 32'hFFFF_FFFF;
      default: ;
    endcase
    return v;
  endfunction

  task automatic push_item(input logic [7:0] cb, input logic st);
    lspe_pkg::in_item_t it;
    it.cover_byte  = cb;
    it.image_start = st;
    frame_q.push_back(it);
  endtask

  // hide n bits of v, lsb first, in bit 0 of random bytes
  task automatic push_bits(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) push_item({7'($urandom), v[i % 32]}, 1'b0);
  endtask

  task automatic send_frame();
    int gap;
    foreach (frame_q[i]) begin
      gap = burst_tx ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= frame_q[i];
      do @(posedge clk); while (!in_ready);
      items_sent++;
    end
  endtask

  // let every pending result out, then give the pipe time to empty
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_due != 0);
    repeat (5) @(posedge clk);
  endtask

  task automatic cfg_write(input lspe_pkg::reg_idx_t idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  initial begin : stimulus
    frame_kind_t kind;
    int          r;
    logic [31:0] ext_n;
    logic [31:0] pay_n;
    logic [7:0]  c1;
    logic [7:0]  c2;

    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    end_check   <= 1'b0;
    hl_set      = lspe_pkg::HDR_LEN_RST;
    m1_set      = lspe_pkg::MAGIC_1_RST;
    m2_set      = lspe_pkg::MAGIC_2_RST;
    en_set      = lspe_pkg::MAGIC_EN_RST;
    items_sent  = 0;
    burst_tx    = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: no header, reset magic values; bad first char, then bad second char
    cfg_write(lspe_pkg::REG_HDR_LEN, {24'($urandom), 8'd0});
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    hl_set = 8'd0;
    frame_q.delete();
    for (int i = 0; i < 8; i++) push_item(i[0] ? 8'h01 : 8'hFF, i == 0);
    push_item(8'h00, 1'b0);
    for (int i = 0; i < 8; i++) push_item(m1_set[i] ? 8'hFF : 8'hFE, i == 0);
    for (int i = 0; i < 8; i++) push_item(i[0] ? 8'hFE : 8'h00, 1'b0);
    send_frame();

    for (int f = 0; items_sent < ITEM_TARGET; f++) begin
      if (f < 4 || $urandom_range(0, 1) == 1) begin
        drain();
        r = $urandom_range(0, 15);
        case (f)
          1: begin
            hl_set = 8'd255;
            m1_set = 8'd255;
            m2_set = 8'd0;
            en_set = 1'b1;
          end
          2: begin
            hl_set = 8'd0;
            m1_set = 8'd0;
            m2_set = 8'd255;
            en_set = 1'b0;
          end
          default: begin
            hl_set = (r == 0) ? 8'd255 : (r == 1) ? lspe_pkg::HDR_LEN_RST :
                     (r == 2) ? 8'd0 : 8'($urandom_range(0, 6));
            m1_set = (r == 3) ? 8'd0 : (r == 4) ? 8'd255 : 8'($urandom);
            m2_set = (r == 5) ? 8'd255 : (r == 6) ? 8'd0 : 8'($urandom);
            en_set = (f < 9) || ($urandom_range(0, 3) != 0);
          end
        endcase
        cfg_write(lspe_pkg::REG_HDR_LEN,  {24'($urandom), hl_set});
        cfg_write(lspe_pkg::REG_MAGIC_1,  {24'($urandom), m1_set});
        cfg_write(lspe_pkg::REG_MAGIC_2,  {24'($urandom), m2_set});
        cfg_write(lspe_pkg::REG_MAGIC_EN, {31'($urandom), en_set});
        cfg_psel    <= 1'b0;
        cfg_penable <= 1'b0;
      end

      burst_tx = (f % 4 == 3);
      if (f < 9) kind = frame_kind_t'(f);
      else begin
        r = $urandom_range(0, 15);
        if (r < 8) kind = FR_NORMAL;
        else kind = frame_kind_t'(r - 7);
      end

      frame_q.delete();
      ext_n = 32'($urandom_range(1, 4));
      pay_n = 32'($urandom_range(1, 8));
      c1    = m1_set;
      c2    = m2_set;
      case (kind)
        FR_EXT_ZERO:   ext_n = '0;
        FR_EXT_NEG:    ext_n = neg_length();
        FR_PAY_ZERO:   pay_n = '0;
        FR_PAY_NEG:    pay_n = neg_length();
        FR_MAGIC1_BAD: c1 = m1_set ^ 8'($urandom_range(1, 255));
        FR_MAGIC2_BAD: c2 = m2_set ^ 8'($urandom_range(1, 255));
        FR_TRUNCATED:  ext_n = $urandom_range(0, 1) ? 32'h7FFF_FFFF : {2'b01, 30'($urandom)};
        default: ;
      endcase

      if (kind == FR_NOISE) begin
        repeat ($urandom_range(8, 40)) push_item(8'($urandom), $urandom_range(0, 7) == 0);
      end else begin
        repeat (hl_set) push_item(8'($urandom), 1'b0);
        if (en_set) begin
          push_bits(c1, 8);
          if (c1 == m1_set) push_bits(c2, 8);
        end
        if (!en_set || (c1 == m1_set && c2 == m2_set)) begin
          push_bits(ext_n, 32);
          // a huge extension length is cut short by the next image start
          if (kind == FR_TRUNCATED) push_bits($urandom, 8 * $urandom_range(0, 3));
          else begin
            if (positive_len(ext_n)) push_bits($urandom, 8 * ext_n);
            push_bits(pay_n, 32);
            if (positive_len(pay_n))
              for (int k = 0; k < pay_n; k++) push_bits($urandom, 8);
          end
        end
        // trailing bytes past the frame end are dropped by the block
        if (kind != FR_TRUNCATED) repeat ($urandom_range(0, 3)) push_item(8'($urandom), 1'b0);
        frame_q[0].image_start = 1'b1;
      end
      send_frame();
    end

    drain();
    end_check <= 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : rx_side
    int gap;
    int taken;
    bit held;
    bit last_taken;
    out_ready  <= 1'b0;
    taken      = 0;
    held       = 0;
    last_taken = 1'b1;
    do @(posedge clk); while (!rst_n);
    forever begin
      // hold off once mid-frame so the block backs up into its input
      if (!held && taken >= 12 && !last_taken) begin
        gap  = PRESSURE_CYCLES;
        held = 1;
      end else if ((taken / 16) % 2 == 1) gap = 0;
      else gap = $urandom_range(0, 11);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      last_taken = out_data.last;
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
